[rtl/pal_pkg.sv]
// Package for the positional array list: request and response payload types,
// command and status codes, and fixed field widths.
// No dependencies.
`timescale 1ns / 1ps

package pal_pkg;

   // Field widths fixed by the interface
   localparam int CMD_W    = 3;
   localparam int POS_W    = 10;
   localparam int VAL_W    = 8;
   localparam int STATUS_W = 2;
   localparam int CNT_W    = 11;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BADPOS = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [POS_W-1:0] position;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                found;
      logic [VAL_W-1:0]    read_value;
      logic [CNT_W-1:0]    count;
   } rsp_type;

endpackage

[rtl/positional_array_list.sv]
// Positional array list: ordered list of bytes in one on-chip memory with a
// fill count; clear, insert, delete, search and indexed read.
// Depends on pal_pkg.
`timescale 1ns / 1ps

//  channel | ports                           | direction | payload
//  --------+---------------------------------+-----------+------------------
//  request | req_valid, req_stall, req_data  | in        | pal_pkg::req_type
//  response| rsp_valid, rsp_stall, rsp_data  | out       | pal_pkg::rsp_type
//
//  Clear, refused and unknown requests and a delete of the last entry go
//  straight to the response; a read waits on the memory port; an insert
//  shifts later entries up, if any, then stores the byte; other deletes shift
//  entries down; search scans up from slot 0. Shifts and the scan move one
//  entry per cycle through the single-write, single-read memory port pair.
//  One request is in work at a time; req_stall is high until its response
//  is loaded. Reset clears the fill count and control; memory is not cleared.
//  A stalled response holds in the output register.

module positional_array_list #(
   parameter int DEPTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pal_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pal_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W;

   // State codes
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_UP       = 4'd1;
   localparam logic [3:0] S_DN       = 4'd2;
   localparam logic [3:0] S_DRAIN    = 4'd3;
   localparam logic [3:0] S_PUT      = 4'd4;
   localparam logic [3:0] S_SCAN     = 4'd5;
   localparam logic [3:0] S_SCAN_END = 4'd6;
   localparam logic [3:0] S_RD_WAIT  = 4'd7;
   localparam logic [3:0] S_DONE     = 4'd8;

   logic [pal_pkg::VAL_W-1:0] mem [DEPTH];

   logic [3:0]                   state_ff, state_in;
   logic [CW-1:0]                count_ff, count_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         wr_pend_ff, wr_pend_in;
   logic                         chk_ff, chk_in;
   pal_pkg::rsp_type             rsp_ff, rsp_in;
   logic [pal_pkg::CMD_W-1:0]    cmd_ff, cmd_in;
   logic [AW-1:0]                pos_ff, pos_in;
   logic [pal_pkg::VAL_W-1:0]    val_ff, val_in;
   logic [AW-1:0]                idx_ff, idx_in;
   logic [AW-1:0]                wr_addr_ff, wr_addr_in;
   logic [pal_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                         found_ff, found_in;
   logic [pal_pkg::VAL_W-1:0]    rd_ff, rd_in;
   logic [pal_pkg::VAL_W-1:0]    rd_data_ff;

   logic                         mem_we, mem_re;
   logic [AW-1:0]                mem_waddr, mem_raddr;
   logic [pal_pkg::VAL_W-1:0]    mem_wdata;

   logic [XW-1:0]                pos_x, cnt_x, depth_x;
   logic                         match;

   assign pos_x   = XW'(req_data.position);
   assign cnt_x   = XW'(count_ff);
   assign depth_x = XW'(DEPTH);
   assign match   = (rd_data_ff == val_ff);

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Decide, walk the memory, and build the response
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_in       = rsp_ff;
      wr_pend_in   = 1'b0;
      chk_in       = 1'b0;
      cmd_in       = cmd_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      idx_in       = idx_ff;
      wr_addr_in   = wr_addr_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      rd_in        = rd_ff;
      mem_re       = 1'b0;
      mem_raddr    = idx_ff;
      mem_we       = wr_pend_ff;
      mem_waddr    = wr_addr_ff;
      mem_wdata    = rd_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_data.cmd;
               pos_in    = pos_x[AW-1:0];
               val_in    = req_data.value;
               status_in = pal_pkg::STATUS_OK;
               found_in  = 1'b0;
               rd_in     = '0;
               state_in  = S_DONE;
               unique case (req_data.cmd)
                  pal_pkg::CMD_CLEAR: begin
                     count_in = '0;
                  end
                  pal_pkg::CMD_INSERT: begin
                     if (cnt_x >= depth_x) begin
                        status_in = pal_pkg::STATUS_FULL;
                     end else if (pos_x > cnt_x) begin
                        status_in = pal_pkg::STATUS_BADPOS;
                     end else begin
                        count_in = count_ff + CW'(1);
                        if (pos_x == cnt_x) begin
                           state_in = S_PUT;
                        end else begin
                           idx_in   = AW'(cnt_x - XW'(1));
                           state_in = S_UP;
                        end
                     end
                  end
                  pal_pkg::CMD_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = pal_pkg::STATUS_EMPTY;
                     end else if (pos_x >= cnt_x) begin
                        status_in = pal_pkg::STATUS_BADPOS;
                     end else begin
                        count_in = count_ff - CW'(1);
                        if (pos_x != cnt_x - XW'(1)) begin
                           idx_in   = AW'(pos_x + XW'(1));
                           state_in = S_DN;
                        end
                     end
                  end
                  pal_pkg::CMD_SEARCH: begin
                     if (count_ff == '0) begin
                        status_in = pal_pkg::STATUS_EMPTY;
                     end else begin
                        idx_in   = '0;
                        state_in = S_SCAN;
                     end
                  end
                  pal_pkg::CMD_READ: begin
                     if (count_ff == '0) begin
                        status_in = pal_pkg::STATUS_EMPTY;
                     end else if (pos_x >= cnt_x) begin
                        status_in = pal_pkg::STATUS_BADPOS;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = pos_x[AW-1:0];
                        state_in  = S_RD_WAIT;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         // Shift up: read slot i-1, write it to slot i in the next cycle
         S_UP: begin
            mem_re     = 1'b1;
            wr_pend_in = 1'b1;
            wr_addr_in = idx_ff + AW'(1);
            if (idx_ff == pos_ff) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff - AW'(1);
            end
         end
         // Shift down: read slot i+1, write it to slot i in the next cycle
         S_DN: begin
            mem_re     = 1'b1;
            wr_pend_in = 1'b1;
            wr_addr_in = idx_ff - AW'(1);
            if (CW'(idx_ff) == count_ff) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         // Retire the last shift write
         S_DRAIN: begin
            state_in = (cmd_ff == pal_pkg::CMD_INSERT) ? S_PUT : S_DONE;
         end
         // Store the new byte at its slot
         S_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = val_ff;
            state_in  = S_DONE;
         end
         // Scan: issue one read a cycle, compare the previous one
         S_SCAN: begin
            if (chk_ff && match) begin
               found_in = 1'b1;
               state_in = S_DONE;
            end else begin
               mem_re = 1'b1;
               chk_in = 1'b1;
               if (CW'(idx_ff) == count_ff - CW'(1)) begin
                  state_in = S_SCAN_END;
               end else begin
                  idx_in = idx_ff + AW'(1);
               end
            end
         end
         S_SCAN_END: begin
            found_in = chk_ff & match;
            state_in = S_DONE;
         end
         S_RD_WAIT: begin
            rd_in    = rd_data_ff;
            state_in = S_DONE;
         end
         // Load the response once the output register is free
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_in.status     = status_ff;
               rsp_in.found      = found_ff;
               rsp_in.read_value = rd_ff;
               rsp_in.count      = (pal_pkg::CNT_W)'(count_ff);
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         wr_pend_ff   <= 1'b0;
         chk_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_pend_ff   <= wr_pend_in;
         chk_ff       <= chk_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_ff     <= rsp_in;
      cmd_ff     <= cmd_in;
      pos_ff     <= pos_in;
      val_ff     <= val_in;
      idx_ff     <= idx_in;
      wr_addr_ff <= wr_addr_in;
      status_ff  <= status_in;
      found_ff   <= found_in;
      rd_ff      <= rd_in;
   end

   // List memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

`ifndef SYNTHESIS
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside the done state");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count above depth");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !wr_pend_ff)
      else $error("shift write pending while idle");

   a_port_collide: assert property (@(posedge clock) disable iff (reset)
      mem_we && mem_re |-> mem_waddr != mem_raddr)
      else $error("read and write hit the same entry");
`endif

endmodule
